### rtl/rbfh_pkg.sv
// Shared types, codes and constants of the ray/box first-hit picker.
package rbfh_pkg;

   localparam int MAX_BOXES_DEF = 1024;
   localparam int IDX_W         = 10;
   localparam int COORD_W       = 32;
   localparam int DIFF_W        = 33;
   localparam int NUM_W         = 49;
   localparam int DIST_W        = 42;

   localparam logic [1:0] OP_STORE = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_UNDEF = 2'd3;

   localparam logic [1:0] ST_HIT  = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic signed [DIST_W-1:0] OPEN_LOW  = -(42'sd1 <<< 40);
   localparam logic signed [DIST_W-1:0] OPEN_HIGH = (42'sd1 <<< 40);
   localparam logic signed [DIST_W-1:0] QMAX = 42'sd2147483647;
   localparam logic signed [DIST_W-1:0] QMIN = -42'sd2147483648;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_DECIDE,
      S_RESP
   } state_type;

   // Start request to the divider.
   typedef struct packed {
      logic                       start;
      logic signed [NUM_W-1:0]    num;
      logic signed [COORD_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [DIST_W-1:0]   quo;
   } div_rsp_type;

endpackage

### rtl/rbfh_divider.sv
// Shared restoring divider: one quotient bit a cycle, truncating, saturating to Q16.16.
module rbfh_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  rbfh_pkg::div_req_type div_req,
   output rbfh_pkg::div_rsp_type div_rsp
);

   localparam int NW = rbfh_pkg::NUM_W;
   localparam int CW = 6;

   logic [NW-1:0] quo_ff, quo_in;
   logic [NW:0]   rem_ff, rem_in;
   logic [NW-1:0] den_ff, den_in;
   logic          neg_ff, neg_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW:0]   trial;
   logic [NW-1:0] num_abs;
   logic [NW-1:0] den_abs;
   logic signed [NW:0] sq;

   always_comb begin
      num_abs = div_req.num[NW-1] ? (~div_req.num + 1'b1) : div_req.num;
      den_abs = div_req.den[rbfh_pkg::COORD_W-1]
                ? NW'(-{{(NW-rbfh_pkg::COORD_W){div_req.den[rbfh_pkg::COORD_W-1]}},
                        div_req.den})
                : NW'(div_req.den);
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff[NW-1:0], quo_ff[NW-1]} - {1'b0, den_ff};
      if (div_req.start) begin
         quo_in  = num_abs;
         rem_in  = '0;
         den_in  = den_abs;
         neg_in  = div_req.num[NW-1] ^ div_req.den[rbfh_pkg::COORD_W-1];
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
      end else if (busy_ff) begin
         if (!trial[NW]) begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NW-1:0], quo_ff[NW-1]};
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Apply sign, then saturate.
   always_comb begin
      sq = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      div_rsp.done = done_ff;
      if (sq > $signed((NW+1)'(rbfh_pkg::QMAX)))
         div_rsp.quo = rbfh_pkg::QMAX;
      else if (sq < $signed((NW+1)'(rbfh_pkg::QMIN)))
         div_rsp.quo = rbfh_pkg::QMIN;
      else
         div_rsp.quo = rbfh_pkg::DIST_W'(sq);
   end

endmodule

### rtl/ray_box_first_hit_picker_core.sv
// Top level of the ray/box first-hit picker: box table, sequencer and slab test.
// Usage: one request channel (req_*) carries beats with an op code: store a
// box (min corner in first_*, max in second_*), clear the table, or query a
// ray (origin in first_*, direction in second_*). Each beat of op 0..2 yields
// exactly one rsp_* beat; op 3 is dropped with no response.
// A query reads each stored box in table order and runs its slab test
// through one shared 49-step divider, up to six divisions a box; the
// query stops at the first hit.
// The block takes one beat at a time: req_stall is high from acceptance until
// the response has been taken. A stalled response holds its payload.
// Reset (synchronous, active high) empties the table and idles the sequencer;
// the box memory itself is not cleared.
module ray_box_first_hit_picker_core #(
   parameter int MAX_BOXES = rbfh_pkg::MAX_BOXES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic signed [31:0]       req_first_x,
   input  logic signed [31:0]       req_first_y,
   input  logic signed [31:0]       req_first_z,
   input  logic signed [31:0]       req_second_x,
   input  logic signed [31:0]       req_second_y,
   input  logic signed [31:0]       req_second_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [rbfh_pkg::IDX_W-1:0] rsp_box_index
);

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNTW = $clog2(MAX_BOXES + 1);
   localparam int CW = rbfh_pkg::COORD_W;
   localparam int DW = rbfh_pkg::DIST_W;

   logic [6*CW-1:0] box_mem [MAX_BOXES];
   logic [6*CW-1:0] rd_ff;

   rbfh_pkg::state_type state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0] idx_ff, idx_in;
   logic [2:0]      step_ff, step_in;
   logic            pass_ff, pass_in;
   logic signed [DW-1:0] near_ff, near_in, far_ff, far_in;
   logic signed [DW-1:0] t1_ff, t1_in;
   logic signed [CW-1:0] org_ff [3];
   logic signed [CW-1:0] dir_ff [3];
   logic [1:0]      st_ff, st_in;
   logic [rbfh_pkg::IDX_W-1:0] bi_ff, bi_in;
   logic            accept, wr_en;
   logic            issued_ff, issued_in;
   logic            div_start;

   rbfh_pkg::div_req_type div_req;
   rbfh_pkg::div_rsp_type div_rsp;

   logic [1:0]           axis;
   logic signed [CW-1:0] bnd_a, bnd_b, o, d, bnd;
   logic signed [DW-1:0] lo, hi;
   logic                 in_slab;

   rbfh_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept = req_valid && !req_stall;
   assign wr_en  = accept && req_op == rbfh_pkg::OP_STORE && count_ff < CNTW'(MAX_BOXES);

   always_ff @(posedge clock) begin
      if (wr_en)
         box_mem[count_ff[AW-1:0]] <= {req_first_x, req_first_y, req_first_z,
                                       req_second_x, req_second_y, req_second_z};
      rd_ff <= box_mem[idx_ff[AW-1:0]];
   end

   // step: 0..5 = axis*2 + bound
   always_comb begin
      axis  = 2'(step_ff >> 1);
      case (axis)
         2'd0: begin
            bnd_a = rd_ff[6*CW-1 -: CW];
            bnd_b = rd_ff[3*CW-1 -: CW];
         end
         2'd1: begin
            bnd_a = rd_ff[5*CW-1 -: CW];
            bnd_b = rd_ff[2*CW-1 -: CW];
         end
         default: begin
            bnd_a = rd_ff[4*CW-1 -: CW];
            bnd_b = rd_ff[CW-1 -: CW];
         end
      endcase
      o   = org_ff[axis];
      d   = dir_ff[axis];
      bnd = step_ff[0] ? bnd_b : bnd_a;
      in_slab = ((bnd_a < bnd_b) ? (o >= bnd_a && o <= bnd_b)
                                 : (o >= bnd_b && o <= bnd_a));
      lo = (t1_ff < div_rsp.quo) ? t1_ff : div_rsp.quo;
      hi = (t1_ff < div_rsp.quo) ? div_rsp.quo : t1_ff;
      div_req.num = rbfh_pkg::NUM_W'({{(rbfh_pkg::NUM_W-CW){bnd[CW-1]}}, bnd}
                    - {{(rbfh_pkg::NUM_W-CW){o[CW-1]}}, o}) <<< 16;
      div_req.den = d;
      div_req.start = div_start;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbfh_pkg::S_IDLE: begin
            if (accept) begin
               if (req_op == rbfh_pkg::OP_QUERY)
                  state_in = (count_ff == '0) ? rbfh_pkg::S_RESP : rbfh_pkg::S_READ;
               else if (req_op != rbfh_pkg::OP_UNDEF)
                  state_in = rbfh_pkg::S_RESP;
            end
         end
         rbfh_pkg::S_READ: state_in = rbfh_pkg::S_DIV;
         rbfh_pkg::S_DIV: begin
            if (!pass_ff || step_ff == 3'd6)
               state_in = rbfh_pkg::S_DECIDE;
         end
         rbfh_pkg::S_DECIDE: begin
            if ((pass_ff && near_ff < far_ff && far_ff > 0) || idx_ff + 1'b1 == count_ff)
               state_in = rbfh_pkg::S_RESP;
            else
               state_in = rbfh_pkg::S_READ;
         end
         rbfh_pkg::S_RESP: if (!rsp_stall) state_in = rbfh_pkg::S_IDLE;
         default: state_in = rbfh_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      pass_in   = pass_ff;
      near_in   = near_ff;
      far_in    = far_ff;
      t1_in     = t1_ff;
      st_in     = st_ff;
      bi_in     = bi_ff;
      issued_in = issued_ff;
      div_start = 1'b0;
      req_stall = state_ff != rbfh_pkg::S_IDLE;
      rsp_valid = state_ff == rbfh_pkg::S_RESP;
      case (state_ff)
         rbfh_pkg::S_IDLE: begin
            if (accept) begin
               bi_in  = '0;
               idx_in = '0;
               case (req_op)
                  rbfh_pkg::OP_STORE: begin
                     if (count_ff < CNTW'(MAX_BOXES)) begin
                        st_in    = rbfh_pkg::ST_DONE;
                        bi_in    = rbfh_pkg::IDX_W'(count_ff);
                        count_in = count_ff + 1'b1;
                     end else begin
                        st_in = rbfh_pkg::ST_FULL;
                     end
                  end
                  rbfh_pkg::OP_CLEAR: begin
                     st_in    = rbfh_pkg::ST_DONE;
                     count_in = '0;
                  end
                  default: st_in = rbfh_pkg::ST_MISS;
               endcase
            end
         end
         rbfh_pkg::S_READ: begin
            step_in   = '0;
            pass_in   = 1'b1;
            issued_in = 1'b0;
            near_in   = rbfh_pkg::OPEN_LOW;
            far_in    = rbfh_pkg::OPEN_HIGH;
         end
         rbfh_pkg::S_DIV: begin
            if (pass_ff && step_ff != 3'd6) begin
               if (d == '0) begin
                  // zero direction: origin must lie in the slab
                  pass_in = in_slab;
                  step_in = step_ff + 3'd2;
               end else if (!issued_ff) begin
                  div_start = 1'b1;
                  issued_in = 1'b1;
               end else if (div_rsp.done) begin
                  issued_in = 1'b0;
                  step_in   = step_ff + 3'd1;
                  if (!step_ff[0]) begin
                     t1_in = div_rsp.quo;
                  end else begin
                     if (lo > near_ff) near_in = lo;
                     if (hi < far_ff)  far_in  = hi;
                  end
               end
            end
         end
         rbfh_pkg::S_DECIDE: begin
            if (pass_ff && near_ff < far_ff && far_ff > 0) begin
               st_in = rbfh_pkg::ST_HIT;
               bi_in = rbfh_pkg::IDX_W'(idx_ff);
            end else if (idx_ff + 1'b1 == count_ff) begin
               st_in = rbfh_pkg::ST_MISS;
               bi_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbfh_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      step_ff   <= step_in;
      pass_ff   <= pass_in;
      near_ff   <= near_in;
      far_ff    <= far_in;
      t1_ff     <= t1_in;
      st_ff     <= st_in;
      bi_ff     <= bi_in;
      issued_ff <= issued_in;
      if (accept) begin
         org_ff[0] <= req_first_x;
         org_ff[1] <= req_first_y;
         org_ff[2] <= req_first_z;
         dir_ff[0] <= req_second_x;
         dir_ff[1] <= req_second_y;
         dir_ff[2] <= req_second_z;
      end
   end

   assign rsp_status    = st_ff;
   assign rsp_box_index = bi_ff;

endmodule

### tb/tb_ray_box_first_hit_picker_core.sv
// Testbench for the ray/box first-hit picker: box table, slab-test predictor and checks.
module tb_ray_box_first_hit_picker_core;

   class hit_scoreboard;
      int               box_lo [3][rbfh_pkg::MAX_BOXES_DEF];
      int               box_hi [3][rbfh_pkg::MAX_BOXES_DEF];
      int unsigned      box_total;
      logic [1:0]       want_status [$];
      logic [rbfh_pkg::IDX_W-1:0] want_index [$];
      int unsigned      errors;

      function new();
         box_total = 0;
         errors    = 0;
      endfunction

      // Distance along the ray to one slab plane, saturated to Q16.16.
      function longint plane_dist(longint bound, longint org, longint dir);
         longint q;
         q = ((bound - org) * 65536) / dir;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q;
      endfunction

      function bit slab_pass(longint a, longint b, longint org, longint dir,
                             inout longint near_t, inout longint far_t);
         longint t1, t2, lo, hi;
         if (dir == 0) begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            return (org >= lo) && (org <= hi);
         end
         t1 = plane_dist(a, org, dir);
         t2 = plane_dist(b, org, dir);
         lo = (t1 < t2) ? t1 : t2;
         hi = (t1 < t2) ? t2 : t1;
         if (lo > near_t) near_t = lo;
         if (hi < far_t) far_t = hi;
         return 1'b1;
      endfunction

      function bit ray_hits(int unsigned i, int org [3], int dir [3]);
         longint near_t, far_t;
         near_t = -(64'sd1 <<< 40);
         far_t  = (64'sd1 <<< 40);
         for (int k = 0; k < 3; k++)
            if (!slab_pass(box_lo[k][i], box_hi[k][i], org[k], dir[k], near_t, far_t))
               return 1'b0;
         return (near_t < far_t) && (far_t > 0);
      endfunction

      function void note_request(logic [1:0] op, int first [3], int second [3]);
         logic [1:0]       st;
         logic [rbfh_pkg::IDX_W-1:0] idx;
         st  = rbfh_pkg::ST_MISS;
         idx = '0;
         case (op)
            rbfh_pkg::OP_STORE: begin
               if (box_total >= rbfh_pkg::MAX_BOXES_DEF) begin
                  st = rbfh_pkg::ST_FULL;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     box_lo[k][box_total] = first[k];
                     box_hi[k][box_total] = second[k];
                  end
                  st  = rbfh_pkg::ST_DONE;
                  idx = box_total[rbfh_pkg::IDX_W-1:0];
                  box_total++;
               end
            end
            rbfh_pkg::OP_CLEAR: begin
               box_total = 0;
               st = rbfh_pkg::ST_DONE;
            end
            rbfh_pkg::OP_QUERY: begin
               for (int unsigned i = 0; i < box_total; i++)
                  if (ray_hits(i, first, second)) begin
                     st  = rbfh_pkg::ST_HIT;
                     idx = i[rbfh_pkg::IDX_W-1:0];
                     break;
                  end
            end
            default: return;
         endcase
         want_status = {want_status, st};
         want_index  = {want_index, idx};
      endfunction

      function void check_result(logic [1:0] st, logic [rbfh_pkg::IDX_W-1:0] idx);
         logic [1:0]       es;
         logic [rbfh_pkg::IDX_W-1:0] ei;
         if (want_status.size() == 0) begin
            $error("unexpected result beat: status %0d box_index %0d", st, idx);
            errors++;
            return;
         end
         es = want_status.pop_front();
         ei = want_index.pop_front();
         if (st !== es) begin
            $error("status mismatch: expected %0d actual %0d", es, st);
            errors++;
         end
         if (idx !== ei) begin
            $error("box_index mismatch: expected %0d actual %0d", ei, idx);
            errors++;
         end
      endfunction

      function int pending();
         return want_status.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_op = rbfh_pkg::OP_CLEAR;
   logic signed [31:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic signed [31:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [rbfh_pkg::IDX_W-1:0] rsp_box_index;

   hit_scoreboard book = new();
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;

   ray_box_first_hit_picker_core dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_status, rsp_box_index);

   task automatic send_beat(logic [1:0] op, int first [3], int second [3]);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_first_x  <= first[0];
      req_first_y  <= first[1];
      req_first_z  <= first[2];
      req_second_x <= second[0];
      req_second_y <= second[1];
      req_second_z <= second[2];
      do @(posedge clock); while (req_stall);
      book.note_request(op, first, second);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
   endtask

   // Small Q16.16 value in whole units plus a random fraction.
   function automatic int near_coord(int span);
      return ($urandom_range(2 * span) - span) * 65536 + $urandom_range(65535);
   endfunction

   task automatic random_beat();
      int first [3], second [3];
      int pick, c, r;
      pick = $urandom_range(99);
      if (book.box_total >= 6 || pick < 6) begin
         send_beat(rbfh_pkg::OP_CLEAR, '{$urandom, $urandom, $urandom},
                   '{$urandom, $urandom, $urandom});
      end else if (pick < 50) begin
         for (int k = 0; k < 3; k++) begin
            c = near_coord(10);
            r = $urandom_range(1, 5) * 65536;
            first[k]  = c - r;
            second[k] = c + r;
            if ($urandom_range(9) == 0) begin
               first[k]  = c + r;
               second[k] = c - r;
            end
            if ($urandom_range(19) == 0) first[k] = $urandom;
            if ($urandom_range(19) == 0) second[k] = $urandom;
         end
         send_beat(rbfh_pkg::OP_STORE, first, second);
      end else if (pick < 95) begin
         for (int k = 0; k < 3; k++) begin
            first[k]  = near_coord(40);
            second[k] = near_coord(10) - first[k];
            if ($urandom_range(7) == 0) second[k] = 0;
            if ($urandom_range(19) == 0) first[k] = $urandom;
            if ($urandom_range(19) == 0) second[k] = $urandom;
         end
         send_beat(rbfh_pkg::OP_QUERY, first, second);
      end else begin
         // undefined op: dropped without a result
         send_beat(rbfh_pkg::OP_UNDEF, '{$urandom, $urandom, $urandom},
                   '{$urandom, $urandom, $urandom});
      end
   endtask

   localparam int MAXV = 32'h7fffffff;
   localparam int MINV = 32'h80000000;
   localparam int ONE  = 65536;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, zero directions, swapped bounds, dropped op.
      send_beat(rbfh_pkg::OP_QUERY, '{0, 0, 0}, '{ONE, ONE, ONE});
      send_beat(rbfh_pkg::OP_STORE, '{MINV, MINV, MINV}, '{MAXV, MAXV, MAXV});
      send_beat(rbfh_pkg::OP_QUERY, '{0, 0, 0}, '{0, 0, 0});
      send_beat(rbfh_pkg::OP_QUERY, '{MAXV, MINV, MAXV}, '{MINV, MAXV, 1});
      send_beat(rbfh_pkg::OP_QUERY, '{MINV, MINV, MINV}, '{-1, -1, -1});
      send_beat(rbfh_pkg::OP_CLEAR, '{0, 0, 0}, '{0, 0, 0});
      send_beat(rbfh_pkg::OP_STORE, '{5 * ONE, 5 * ONE, 5 * ONE}, '{ONE, ONE, ONE});
      send_beat(rbfh_pkg::OP_STORE, '{-ONE, -ONE, -ONE}, '{ONE, ONE, ONE});
      send_beat(rbfh_pkg::OP_QUERY, '{3 * ONE, 3 * ONE, 3 * ONE}, '{0, 0, 0});
      send_beat(rbfh_pkg::OP_QUERY, '{3 * ONE, 3 * ONE, 9 * ONE}, '{0, 0, 0});
      send_beat(rbfh_pkg::OP_QUERY, '{0, 0, -9 * ONE}, '{0, 0, ONE});
      send_beat(rbfh_pkg::OP_QUERY, '{0, 0, 9 * ONE}, '{0, 0, ONE});
      send_beat(rbfh_pkg::OP_QUERY, '{ONE, 0, 0}, '{-ONE, 0, 0});
      send_beat(rbfh_pkg::OP_QUERY, '{9 * ONE, 9 * ONE, 9 * ONE}, '{-1, -1, -1});
      send_beat(rbfh_pkg::OP_QUERY, '{0, 0, 0}, '{MAXV, MINV, 1});
      send_beat(rbfh_pkg::OP_UNDEF, '{MAXV, MAXV, MAXV}, '{MINV, MINV, MINV});
      send_beat(rbfh_pkg::OP_CLEAR, '{MINV, MAXV, -1}, '{-1, MAXV, MINV});

      // Fill the table, store once more into a full table, then hit box one.
      for (int i = 0; i < rbfh_pkg::MAX_BOXES_DEF; i++)
         send_beat(rbfh_pkg::OP_STORE, '{-ONE, -ONE, -ONE}, '{i * 8, ONE, ONE});
      send_beat(rbfh_pkg::OP_STORE, '{0, 0, 0}, '{ONE, ONE, ONE});
      send_beat(rbfh_pkg::OP_QUERY, '{0, 0, 0}, '{ONE, 0, 0});
      send_beat(rbfh_pkg::OP_CLEAR, '{0, 0, 0}, '{0, 0, 0});
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         for (int n = 0; n < 115; n++) begin
            random_beat();
            if (n == 60) drain_results();
         end
         // a stretch with no idling at all
         send_idle_pct = 0;
         recv_stall_pct = 0;
         repeat (5) random_beat();
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (book.pending() != 0)
            $error("%0d expected results never arrived", book.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
